@@ hdl/tied_pkg.sv @@
// ----------------------------------------------------------------------------
// tied_pkg: shared types and constants of the enthalpy-delta block
// Item layouts, status and unit codes, table geometry and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tied_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int PTS_W       = 7;

	// field widths
	localparam int TEMP_W = 18;
	localparam int ENTH_W = 20;
	localparam int DLT_W  = 21;

	// Fahrenheit conversion: x = (t - 32.0)*5 + 4, then x/9 by reciprocal
	localparam int                XF_W        = 21;
	localparam logic [TEMP_W-1:0] FREEZE_F_Q8 = 18'd8192;
	localparam logic [XF_W-1:0]   RECIP_9     = 21'd1864136;
	localparam int                RECIP_SH    = 24;

	// interpolation divider: magnitude of (de * dt) is below 2^(ENTH_W+TEMP_W)
	localparam int DIV_W  = ENTH_W + TEMP_W;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int PROD_W = DLT_W + TEMP_W + 1;

	// opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// unit codes
	localparam logic [1:0] UNIT_C = 2'd0;
	localparam logic [1:0] UNIT_F = 2'd1;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_UNIT = 2'd1;
	localparam logic [1:0] ST_OUTSIDE  = 2'd2;
	localparam logic [1:0] ST_LOAD_ACK = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [5:0]        point_index;
		logic [TEMP_W-1:0] point_temp;
		logic [ENTH_W-1:0] point_enthalpy;
		logic [TEMP_W-1:0] initial_temp;
		logic [1:0]        initial_unit;
		logic [TEMP_W-1:0] final_temp;
		logic [1:0]        final_unit;
	} in_item_t;

	typedef struct packed {
		logic signed [DLT_W-1:0] energy_delta;
		logic [1:0]              status;
	} out_item_t;

	// one table point as stored in memory
	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [ENTH_W-1:0] enthalpy;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// divider launch
	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [TEMP_W-1:0] divisor;
	} div_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_START,
		S_SEARCH,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_FIN,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

@@ hdl/tied_if.sv @@
// ----------------------------------------------------------------------------
// tied_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tied_req_if;
	logic                valid;
	logic                ready;
	tied_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tied_rsp_if;
	logic                valid;
	logic                ready;
	tied_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/tied_ram.sv @@
// ----------------------------------------------------------------------------
// tied_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tied_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 38
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/tied_div.sv @@
// ----------------------------------------------------------------------------
// tied_div: radix-2 restoring divider
// Unsigned dividend by unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tied_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tied_pkg::div_req_t            req,
	output logic                               done,
	output logic [tied_pkg::DIV_W-1:0]         quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [tied_pkg::CNT_W-1:0]      cnt_q;
	logic [tied_pkg::TEMP_W-1:0]     rem_q;
	logic [tied_pkg::TEMP_W-1:0]     den_q;
	logic [tied_pkg::DIV_W-1:0]      quo_q;
	logic [tied_pkg::TEMP_W:0]       trial;
	logic [tied_pkg::TEMP_W:0]       diff;
	logic                            qbit;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, quo_q[tied_pkg::DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tied_pkg::CNT_W'(tied_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tied_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[tied_pkg::TEMP_W-1:0] : trial[tied_pkg::TEMP_W-1:0];
			quo_q <= {quo_q[tied_pkg::DIV_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ hdl/table_interpolated_enthalpy_delta.sv @@
// ----------------------------------------------------------------------------
// table_interpolated_enthalpy_delta: enthalpy change from a temperature table
// Loads table points and answers queries by piecewise-linear interpolation.
// ----------------------------------------------------------------------------
// One item is worked at a time. A load, a bad unit code or a Fahrenheit
// temperature below freezing goes straight to the response state. A query
// handles its two temperatures one after the other: each one walks the
// table from slot 0 through the single memory read port, one point per
// cycle, until its segment is found, then passes the multiply state and the
// bit-serial divider. A temperature that lands exactly on the last point
// skips the multiply and the divide. The memory is not cleared at reset:
// query only slots that have been loaded.
// Results sit in an output register, so a new item is taken while the last
// result still waits.
`default_nettype none

module table_interpolated_enthalpy_delta (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tied_pkg::PTS_W-1:0]  cfg_wdata,
	tied_req_if.sink                         req,
	tied_rsp_if.source                       rsp
);

	tied_pkg::state_t                   state_q, state_d;
	logic [tied_pkg::PTS_W-1:0]         pts_q;
	logic [tied_pkg::IDX_W-1:0]         n_last;
	logic [tied_pkg::IDX_W-1:0]         k_q;
	logic                               sel_q;
	logic [tied_pkg::XF_W-1:0]          x_q [2];
	logic                               fahr_q [2];
	logic [tied_pkg::TEMP_W-1:0]        cel_q [2];
	logic signed [tied_pkg::DLT_W-1:0]  e_q [2];
	tied_pkg::entry_t                   prev_q, lo_q, hi_q, cur;
	logic signed [tied_pkg::PROD_W-1:0] num_q;
	logic [tied_pkg::TEMP_W-1:0]        den_q;
	logic                               neg_q;
	tied_pkg::out_item_t                res_q, rsp_data_q;
	logic                               rsp_v_q;

	logic                               req_xfer, is_load, bad_unit, cold;
	logic                               ram_we, ram_re;
	logic [tied_pkg::IDX_W-1:0]         ram_raddr;
	logic [tied_pkg::ENTRY_W-1:0]       ram_rdata;
	logic [tied_pkg::TEMP_W-1:0]        t_cur;
	logic                               seg_hit, at_last, end_hit, slot_free;
	logic [2*tied_pkg::XF_W-1:0]        cprod [2];
	logic signed [tied_pkg::DLT_W-1:0]  de;
	logic [tied_pkg::TEMP_W-1:0]        dt;
	logic signed [tied_pkg::PROD_W-1:0] prod;
	logic [tied_pkg::PROD_W-1:0]        num_mag;
	tied_pkg::div_req_t                 div_req;
	logic                               div_done;
	logic [tied_pkg::DIV_W-1:0]         div_quo;
	logic signed [tied_pkg::DLT_W-1:0]  qv, e_div;

	// (t - 32.0)*5 + 4 in Q8, valid for t at or above freezing
	function automatic logic [tied_pkg::XF_W-1:0] f_scale(
		input logic [tied_pkg::TEMP_W-1:0] t
	);
		logic [tied_pkg::XF_W-1:0] d;
		d = tied_pkg::XF_W'(t - tied_pkg::FREEZE_F_Q8);
		return tied_pkg::XF_W'(d * tied_pkg::XF_W'(5) + tied_pkg::XF_W'(4));
	endfunction

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= tied_pkg::PTS_W'(2);
		end else if (cfg_we) begin
			pts_q <= cfg_wdata;
		end
	end

	// last active slot, point count clamped to 2 .. depth
	always_comb begin
		if (pts_q < tied_pkg::PTS_W'(2)) begin
			n_last = tied_pkg::IDX_W'(1);
		end else if (32'(pts_q) > tied_pkg::TABLE_DEPTH) begin
			n_last = tied_pkg::IDX_W'(tied_pkg::TABLE_DEPTH - 1);
		end else begin
			n_last = tied_pkg::IDX_W'(pts_q - tied_pkg::PTS_W'(1));
		end
	end

	// table memory
	assign ram_we = req_xfer && is_load &&
		(32'(req.data.point_index) < tied_pkg::TABLE_DEPTH);

	tied_ram #(
		.DEPTH (tied_pkg::TABLE_DEPTH),
		.WIDTH (tied_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tied_pkg::IDX_W'(req.data.point_index)),
		.wdata ({req.data.point_temp, req.data.point_enthalpy}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// input decode
	always_comb begin
		req_xfer = req.valid && req.ready;
		is_load  = (req.data.opcode == tied_pkg::OP_LOAD);
		bad_unit = (req.data.initial_unit > tied_pkg::UNIT_F) ||
			(req.data.final_unit > tied_pkg::UNIT_F);
		cold     = ((req.data.initial_unit == tied_pkg::UNIT_F) &&
			(req.data.initial_temp < tied_pkg::FREEZE_F_Q8)) ||
			((req.data.final_unit == tied_pkg::UNIT_F) &&
			(req.data.final_temp < tied_pkg::FREEZE_F_Q8));
	end

	// search compare
	always_comb begin
		cur     = tied_pkg::entry_t'(ram_rdata);
		t_cur   = cel_q[sel_q];
		seg_hit = (prev_q.temp <= t_cur) && (t_cur < cur.temp);
		at_last = (k_q == n_last);
		end_hit = (t_cur == cur.temp);
	end

	// Fahrenheit divide by 9 through the reciprocal
	always_comb begin
		cprod[0] = x_q[0] * tied_pkg::RECIP_9;
		cprod[1] = x_q[1] * tied_pkg::RECIP_9;
	end

	// interpolation product and signed quotient
	always_comb begin
		de      = $signed({1'b0, hi_q.enthalpy}) - $signed({1'b0, lo_q.enthalpy});
		dt      = t_cur - lo_q.temp;
		prod    = tied_pkg::PROD_W'(de * $signed({1'b0, dt}));
		num_mag = neg_q ? tied_pkg::PROD_W'(-num_q) : tied_pkg::PROD_W'(num_q);
		qv      = $signed({1'b0, div_quo[tied_pkg::ENTH_W-1:0]});
		e_div   = $signed({1'b0, lo_q.enthalpy}) + (neg_q ? -qv : qv);
	end

	assign div_req.dividend = num_mag[tied_pkg::DIV_W-1:0];
	assign div_req.divisor  = den_q;
	assign div_req.start    = (state_q == tied_pkg::S_DIVGO);

	tied_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// output slot can take a result this cycle
	assign slot_free = !rsp_v_q || rsp.ready;

	// next state and memory read control
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			tied_pkg::S_IDLE: begin
				if (req_xfer) begin
					if (is_load || bad_unit || cold) begin
						state_d = tied_pkg::S_RESP;
					end else begin
						state_d = tied_pkg::S_CONV;
					end
				end
			end
			tied_pkg::S_CONV: begin
				state_d = tied_pkg::S_START;
			end
			tied_pkg::S_START: begin
				ram_re  = 1'b1;
				state_d = tied_pkg::S_SEARCH;
			end
			tied_pkg::S_SEARCH: begin
				if (k_q == '0) begin
					ram_re    = 1'b1;
					ram_raddr = k_q + 1'b1;
				end else if (seg_hit) begin
					state_d = tied_pkg::S_MUL;
				end else if (at_last) begin
					if (!end_hit) begin
						state_d = tied_pkg::S_RESP;
					end else if (sel_q) begin
						state_d = tied_pkg::S_FIN;
					end else begin
						state_d = tied_pkg::S_START;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = k_q + 1'b1;
				end
			end
			tied_pkg::S_MUL: begin
				state_d = tied_pkg::S_DIVGO;
			end
			tied_pkg::S_DIVGO: begin
				state_d = tied_pkg::S_DIV;
			end
			tied_pkg::S_DIV: begin
				if (div_done) begin
					state_d = sel_q ? tied_pkg::S_FIN : tied_pkg::S_START;
				end
			end
			tied_pkg::S_FIN: begin
				state_d = tied_pkg::S_RESP;
			end
			tied_pkg::S_RESP: begin
				if (slot_free) begin
					state_d = tied_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tied_pkg::S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tied_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tied_pkg::S_IDLE: begin
				sel_q <= 1'b0;
				res_q.energy_delta <= '0;
				if (is_load) begin
					res_q.status <= tied_pkg::ST_LOAD_ACK;
				end else if (bad_unit) begin
					res_q.status <= tied_pkg::ST_BAD_UNIT;
				end else begin
					res_q.status <= tied_pkg::ST_OUTSIDE;
				end
				fahr_q[0] <= (req.data.initial_unit == tied_pkg::UNIT_F);
				fahr_q[1] <= (req.data.final_unit == tied_pkg::UNIT_F);
				x_q[0] <= (req.data.initial_unit == tied_pkg::UNIT_F) ?
					f_scale(req.data.initial_temp) :
					tied_pkg::XF_W'(req.data.initial_temp);
				x_q[1] <= (req.data.final_unit == tied_pkg::UNIT_F) ?
					f_scale(req.data.final_temp) :
					tied_pkg::XF_W'(req.data.final_temp);
			end
			tied_pkg::S_CONV: begin
				cel_q[0] <= fahr_q[0] ?
					cprod[0][tied_pkg::RECIP_SH +: tied_pkg::TEMP_W] :
					x_q[0][tied_pkg::TEMP_W-1:0];
				cel_q[1] <= fahr_q[1] ?
					cprod[1][tied_pkg::RECIP_SH +: tied_pkg::TEMP_W] :
					x_q[1][tied_pkg::TEMP_W-1:0];
			end
			tied_pkg::S_START: begin
				k_q <= '0;
			end
			tied_pkg::S_SEARCH: begin
				if (k_q == '0) begin
					prev_q <= cur;
					k_q    <= k_q + 1'b1;
				end else if (seg_hit) begin
					lo_q <= prev_q;
					hi_q <= cur;
				end else if (at_last) begin
					if (end_hit) begin
						e_q[sel_q] <= $signed({1'b0, cur.enthalpy});
						sel_q      <= 1'b1;
					end
				end else begin
					prev_q <= cur;
					k_q    <= k_q + 1'b1;
				end
			end
			tied_pkg::S_MUL: begin
				num_q <= prod;
				neg_q <= prod[tied_pkg::PROD_W-1];
				den_q <= hi_q.temp - lo_q.temp;
			end
			tied_pkg::S_DIV: begin
				if (div_done) begin
					e_q[sel_q] <= e_div;
					sel_q      <= 1'b1;
				end
			end
			tied_pkg::S_FIN: begin
				res_q.energy_delta <= e_q[1] - e_q[0];
				res_q.status       <= tied_pkg::ST_OK;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (state_q == tied_pkg::S_RESP && slot_free) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tied_pkg::S_RESP && slot_free) begin
			rsp_data_q <= res_q;
		end
	end

	assign req.ready = (state_q == tied_pkg::S_IDLE);
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_data_q;

endmodule

`default_nettype wire

@@ hdl/tied_chk.sv @@
// ----------------------------------------------------------------------------
// tied_chk: port-level checks for the enthalpy-delta block
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tied_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_ready,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic signed [tied_pkg::DLT_W-1:0] rsp_delta,
	input wire logic [1:0]                        rsp_status
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_delta) && $stable(rsp_status))
		else $error("response changed while stalled");

	// every non-ok answer carries a zero delta
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != tied_pkg::ST_OK) |-> rsp_delta == '0)
		else $error("nonzero delta with error or load status");

	// one item at a time: no request transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in work");

	// a result rises only when req_ready was low just before
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without work");

endmodule

bind table_interpolated_enthalpy_delta tied_chk u_tied_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_delta  (rsp.data.energy_delta),
	.rsp_status (rsp.data.status)
);

`default_nettype wire
